// ===== rtl/tcpq_pkg.sv =====
`timescale 1ns / 1ps

package tcpq_pkg;

  // Default sizes
  localparam int DEF_CLASS_DEPTH = 16;
  localparam int DEF_HANDLE_BITS = 8;

  localparam int NUM_CLASSES = 3;
  localparam int CLASS_W     = 2;
  localparam int STATUS_W    = 2;
  localparam int IO_HANDLE_W = 8;
  localparam int TOTAL_W     = 6;

  // Request kinds
  localparam logic REQ_ENQUEUE = 1'b0;
  localparam logic REQ_DEQUEUE = 1'b1;

  // Class codes; the spare code is served as low
  localparam logic [CLASS_W-1:0] CLS_HIGH   = 2'd0;
  localparam logic [CLASS_W-1:0] CLS_SYSTEM = 2'd1;
  localparam logic [CLASS_W-1:0] CLS_LOW    = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_ENQUEUED = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_DEQUEUED = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY    = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic take_item;    // request accepted this cycle
    logic fill_handle;  // store read data is valid, load the result handle
  } tcpq_cmd_t;

endpackage

// ===== rtl/three_class_priority_queue.sv =====
`timescale 1ns / 1ps
// Channel  Direction  Handshake             tdata (low bit up)                tuser
// in_      slave      in_tvalid/in_tready   msg_handle[7:0], msg_class[9:8]   req_type
// out_     master     out_tvalid/out_tready out_handle[7:0], out_class[9:8],  status
//                                           total_count[15:10]
//
// Enqueue results appear in the cycle after acceptance; dequeue results pass the class
// store read register, then the result register. One request is in flight at a time.
// The next request is accepted while a result waits, provided it is taken that cycle.
// Synchronous active-low reset empties all classes; stores need no clearing.
// A stall on out_tready holds the result and stops acceptance.

module three_class_priority_queue
  import tcpq_pkg::*;
#(
  parameter int CLASS_DEPTH = DEF_CLASS_DEPTH,
  parameter int HANDLE_BITS = DEF_HANDLE_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // msg_handle[7:0], msg_class[9:8], zero fill
  input  logic        in_tuser,   // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // out_handle[7:0], out_class[9:8], total_count[15:10]
  output logic [1:0]  out_tuser   // status
);

  tcpq_cmd_t              cmd;
  logic [IO_HANDLE_W-1:0] res_handle;
  logic [CLASS_W-1:0]     res_class;
  logic [TOTAL_W-1:0]     res_total;
  logic [STATUS_W-1:0]    res_status;

  tcpq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .req_type   (in_tuser),
    .out_tready (out_tready),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .cmd        (cmd)
  );

  tcpq_dpath #(
    .CLASS_DEPTH (CLASS_DEPTH),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .req_type    (in_tuser),
    .msg_handle  (in_tdata[7:0]),
    .msg_class   (in_tdata[9:8]),
    .status      (res_status),
    .out_handle  (res_handle),
    .out_class   (res_class),
    .total_count (res_total)
  );

  assign out_tdata = {res_total, res_class, res_handle};
  assign out_tuser = res_status;

endmodule

// ===== rtl/tcpq_ctrl.sv =====
`timescale 1ns / 1ps

module tcpq_ctrl
  import tcpq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  input  logic      req_type,
  input  logic      out_tready,
  output logic      in_tready,
  output logic      out_tvalid,
  output tcpq_cmd_t cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic take;

  // Accept only when idle and the result register is free or draining
  assign in_tready = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign take      = in_tvalid && in_tready;

  assign cmd.take_item   = take;
  assign cmd.fill_handle = (state_r == ST_READ);
  assign out_tvalid      = out_valid_r;

  // Next state and result valid
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    case (state_r)
      ST_IDLE: begin
        if (take) begin
          if (req_type == REQ_DEQUEUE) begin
            state_nxt     = ST_READ;
            out_valid_nxt = 1'b0;
          end else begin
            out_valid_nxt = 1'b1;
          end
        end else if (out_tready) begin
          out_valid_nxt = 1'b0;
        end
      end
      ST_READ: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b1;
      end
      default: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // The store read wait always ends in idle with a result pending
  a_read_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_READ |=> state_r == ST_IDLE && out_valid_r)
    else $error("read wait did not end after one cycle");

  // A dequeue always passes through the read wait with no result pending
  a_deq_to_read: assert property (@(posedge clk) disable iff (!rst_n)
    take && req_type == REQ_DEQUEUE |=> state_r == ST_READ && !out_valid_r)
    else $error("dequeue did not enter read wait");

  // No item taken while a result would be overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |-> !take)
    else $error("item taken over a pending result");

endmodule

// ===== rtl/tcpq_dpath.sv =====
`timescale 1ns / 1ps

module tcpq_dpath
  import tcpq_pkg::*;
#(
  parameter int CLASS_DEPTH = DEF_CLASS_DEPTH,
  parameter int HANDLE_BITS = DEF_HANDLE_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  tcpq_cmd_t              cmd,
  input  logic                   req_type,
  input  logic [IO_HANDLE_W-1:0] msg_handle,
  input  logic [CLASS_W-1:0]     msg_class,
  output logic [STATUS_W-1:0]    status,
  output logic [IO_HANDLE_W-1:0] out_handle,
  output logic [CLASS_W-1:0]     out_class,
  output logic [TOTAL_W-1:0]     total_count
);

  localparam int PTR_W = $clog2(CLASS_DEPTH);
  localparam int CNT_W = $clog2(CLASS_DEPTH + 1);

  logic [PTR_W-1:0] rptr_r  [NUM_CLASSES];
  logic [PTR_W-1:0] wptr_r  [NUM_CLASSES];
  logic [CNT_W-1:0] count_r [NUM_CLASSES];
  logic [TOTAL_W-1:0] total_r, total_nxt;

  logic [HANDLE_BITS-1:0] rd_data_r [NUM_CLASSES];
  logic [HANDLE_BITS+IO_HANDLE_W-1:0] in_wide;
  logic [HANDLE_BITS+IO_HANDLE_W-1:0] rd_wide;
  logic [HANDLE_BITS-1:0] wr_data;
  logic [HANDLE_BITS-1:0] rd_sel;

  logic [CLASS_W-1:0] enq_cls;
  logic [CLASS_W-1:0] deq_cls;
  logic               deq_any;
  logic               enq_full;
  logic               enq_ok;
  logic               deq_ok;

  logic [STATUS_W-1:0]    status_r;
  logic [IO_HANDLE_W-1:0] handle_r;
  logic [CLASS_W-1:0]     class_r;
  logic [TOTAL_W-1:0]     res_total_r;

  // Spare class code joins the low class
  assign enq_cls = (msg_class inside {CLS_HIGH, CLS_SYSTEM}) ? msg_class : CLS_LOW;
  assign enq_full = (count_r[enq_cls] == CNT_W'(CLASS_DEPTH));

  // Strict priority pick
  always_comb begin
    deq_any = 1'b1;
    if (count_r[0] != '0) begin
      deq_cls = CLS_HIGH;
    end else if (count_r[1] != '0) begin
      deq_cls = CLS_SYSTEM;
    end else begin
      deq_cls = CLS_LOW;
      deq_any = (count_r[2] != '0);
    end
  end

  assign enq_ok = cmd.take_item && (req_type == REQ_ENQUEUE) && !enq_full;
  assign deq_ok = cmd.take_item && (req_type == REQ_DEQUEUE) && deq_any;

  // Handle width conversion in and out of the stores
  assign in_wide = {{HANDLE_BITS{1'b0}}, msg_handle};
  assign wr_data = in_wide[HANDLE_BITS-1:0];

  // Per-class store, pointers and count
  for (genvar c = 0; c < NUM_CLASSES; c++) begin : g_class
    logic [HANDLE_BITS-1:0] mem [CLASS_DEPTH];
    logic wr_en, rd_en;

    assign wr_en = enq_ok && (enq_cls == CLASS_W'(c));
    assign rd_en = deq_ok && (deq_cls == CLASS_W'(c));

    always_ff @(posedge clk) begin
      if (wr_en) begin
        mem[wptr_r[c]] <= wr_data;
      end
      if (rd_en) begin
        rd_data_r[c] <= mem[rptr_r[c]];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        rptr_r[c]  <= '0;
        wptr_r[c]  <= '0;
        count_r[c] <= '0;
      end else begin
        if (wr_en) begin
          wptr_r[c]  <= (wptr_r[c] == PTR_W'(CLASS_DEPTH - 1)) ? '0 : wptr_r[c] + 1'b1;
          count_r[c] <= count_r[c] + 1'b1;
        end
        if (rd_en) begin
          rptr_r[c]  <= (rptr_r[c] == PTR_W'(CLASS_DEPTH - 1)) ? '0 : rptr_r[c] + 1'b1;
          count_r[c] <= count_r[c] - 1'b1;
        end
      end
    end
  end

  // Running total, kept modulo the field width
  always_comb begin
    total_nxt = total_r;
    if (enq_ok) begin
      total_nxt = total_r + 1'b1;
    end else if (deq_ok) begin
      total_nxt = total_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
    end else begin
      total_r <= total_nxt;
    end
  end

  // Read data of the class that was served
  always_comb begin
    case (class_r)
      CLS_HIGH:   rd_sel = rd_data_r[0];
      CLS_SYSTEM: rd_sel = rd_data_r[1];
      default:    rd_sel = rd_data_r[2];
    endcase
  end
  assign rd_wide = {{IO_HANDLE_W{1'b0}}, rd_sel};

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      handle_r    <= '0;
      res_total_r <= total_nxt;
      class_r     <= deq_ok ? deq_cls : CLS_HIGH;
      if (req_type == REQ_ENQUEUE) begin
        status_r <= enq_full ? STAT_FULL : STAT_ENQUEUED;
      end else begin
        status_r <= deq_any ? STAT_DEQUEUED : STAT_EMPTY;
      end
    end else if (cmd.fill_handle && status_r == STAT_DEQUEUED) begin
      handle_r <= rd_wide[IO_HANDLE_W-1:0];
    end
  end

  assign status      = status_r;
  assign out_handle  = handle_r;
  assign out_class   = class_r;
  assign total_count = res_total_r;

  // Running total tracks the class counts
  a_total_sum: assert property (@(posedge clk) disable iff (!rst_n)
    total_r == TOTAL_W'({2'b00, count_r[0]} + {2'b00, count_r[1]} + {2'b00, count_r[2]}))
    else $error("total out of step with class counts");

  // A class never holds more than its depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r[0] <= CNT_W'(CLASS_DEPTH) && count_r[1] <= CNT_W'(CLASS_DEPTH)
    && count_r[2] <= CNT_W'(CLASS_DEPTH))
    else $error("class count above depth");

  // Enqueue and dequeue never both act on one request
  a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
    !(enq_ok && deq_ok))
    else $error("enqueue and dequeue in one cycle");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import tcpq_pkg::*;

  localparam int CLASS_DEPTH = DEF_CLASS_DEPTH;
  localparam int HANDLE_BITS = DEF_HANDLE_BITS;
  localparam logic [IO_HANDLE_W-1:0] HANDLE_MASK = IO_HANDLE_W'((1 << HANDLE_BITS) - 1);
  localparam int ITEM_TOTAL  = 450;
  localparam int CALM_FROM   = 400;  // no idling on either side after this many items
  localparam int MAX_REPORTS = 10;

  // Unused class code, served as low
  localparam logic [CLASS_W-1:0] CLS_SPARE = 2'd3;

  // Shapes of a random stretch of requests
  typedef enum int {
    SEG_FILL_ONE,  // mostly enqueues into a single class, runs it into full
    SEG_FILL_ALL,  // mostly enqueues spread over all class codes
    SEG_DRAIN,     // mostly dequeues, runs into empty
    SEG_MIXED      // even mix
  } seg_kind_t;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [IO_HANDLE_W-1:0] handle;
    logic [CLASS_W-1:0]     cls;
    logic [TOTAL_W-1:0]     total;
  } queue_reply_t;

  // Tracks the three class FIFOs and checks every reply in order
  class prio_queue_checker;
    logic [IO_HANDLE_W-1:0] class_fifo [NUM_CLASSES][$];
    queue_reply_t expected_replies[$];
    int unsigned failures;
    int unsigned n_enq, n_deq, n_empty, n_full, peak_held;
    int unsigned deq_per_class [NUM_CLASSES];

    function void note_request(input logic req, input logic [IO_HANDLE_W-1:0] h,
                               input logic [CLASS_W-1:0] c);
      queue_reply_t r;
      logic [CLASS_W-1:0] cls;
      int held;
      r = '0;
      if (req == REQ_ENQUEUE) begin
        // spare class code is served as low
        cls = (c > CLS_LOW) ? CLS_LOW : c;
        if (class_fifo[cls].size() >= CLASS_DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          class_fifo[cls].push_back(h & HANDLE_MASK);
          r.status = STAT_ENQUEUED;
        end
      end else begin
        // strict priority: first nonempty class wins
        r.status = STAT_EMPTY;
        for (int k = 0; k < NUM_CLASSES; k++) begin
          if (r.status == STAT_EMPTY && class_fifo[k].size() != 0) begin
            r.handle = class_fifo[k].pop_front();
            r.cls    = CLASS_W'(k);
            r.status = STAT_DEQUEUED;
          end
        end
      end
      held = class_fifo[0].size() + class_fifo[1].size() + class_fifo[2].size();
      if (held > peak_held) peak_held = held;
      r.total = TOTAL_W'(held);
      expected_replies.push_back(r);
    endfunction

    function void check_reply(input queue_reply_t got);
      queue_reply_t want;
      if (expected_replies.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("unexpected reply: status %0d handle %02h class %0d total %0d",
                   got.status, got.handle, got.cls, got.total);
        return;
      end
      want = expected_replies.pop_front();
      case (want.status)
        STAT_ENQUEUED: n_enq++;
        STAT_DEQUEUED: begin
          n_deq++;
          deq_per_class[want.cls]++;
        end
        STAT_EMPTY:    n_empty++;
        default:       n_full++;
      endcase
      if (got != want) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display({"reply mismatch (exp/act): status %0d/%0d handle %02h/%02h",
                    " class %0d/%0d total %0d/%0d"},
                   want.status, got.status, want.handle, got.handle,
                   want.cls, got.cls, want.total, got.total);
      end
    endfunction

    function void close_out();
      if (expected_replies.size() != 0) begin
        $display("%0d replies never arrived", expected_replies.size());
        failures += expected_replies.size();
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // msg_handle[7:0], msg_class[9:8], zero fill
  logic        in_tuser;   // req_type
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // out_handle[7:0], out_class[9:8], total_count[15:10]
  logic [1:0]  out_tuser;  // status

  prio_queue_checker prio_chk;
  int unsigned items_sent = 0;
  bit calm    = 1'b0;
  bit gaps_on = 1'b1;

  three_class_priority_queue dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("timeout: requests or replies stalled");
    $display("CHECK FAILED");
    $finish;
  end

  // Sink side: ready stretches broken by stall bursts
  initial begin : ready_ctl
    int stall;
    out_tready <= 1'b1;
    forever begin
      repeat ($urandom_range(1, 20)) @(posedge clk);
      if (!calm && $urandom_range(0, 2) != 0) begin
        stall = $urandom_range(1, 6);
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  // Reply monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      prio_chk.check_reply({out_tuser, out_tdata[7:0], out_tdata[9:8], out_tdata[15:10]});
  end

  // Present one request and hold it until accepted
  task automatic send_item(input logic req, input logic [IO_HANDLE_W-1:0] h,
                           input logic [CLASS_W-1:0] c);
    if (gaps_on && !calm && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'd0, c, h};
    in_tuser  <= req;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    prio_chk.note_request(req, h, c);
    items_sent++;
    calm = (items_sent >= CALM_FROM);
  endtask

  initial begin : stimulus
    seg_kind_t seg;
    int len, enq_pct, w;
    logic [CLASS_W-1:0] seg_cls, cls;
    logic req;
    prio_chk = new();
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= REQ_ENQUEUE;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // One per class, spare code included, in reverse priority order
    send_item(REQ_ENQUEUE, 8'h00, CLS_LOW);
    send_item(REQ_ENQUEUE, 8'hFF, CLS_SPARE);
    send_item(REQ_ENQUEUE, 8'hA5, CLS_SYSTEM);
    send_item(REQ_ENQUEUE, 8'h5A, CLS_HIGH);
    // Drain in priority order, last one hits empty
    repeat (5) send_item(REQ_DEQUEUE, 8'hFF, CLS_SPARE);
    // Fill the high class and overflow it once
    for (int i = 0; i <= CLASS_DEPTH; i++)
      send_item(REQ_ENQUEUE, IO_HANDLE_W'(i * 17), CLS_HIGH);

    // Random stretches of fill, drain and mix
    while (items_sent < ITEM_TOTAL) begin
      seg     = seg_kind_t'($urandom_range(0, 3));
      len     = $urandom_range(10, 60);
      seg_cls = CLASS_W'($urandom_range(0, 3));
      gaps_on = ($urandom_range(0, 3) != 0);
      case (seg)
        SEG_FILL_ONE, SEG_FILL_ALL: enq_pct = 90;
        SEG_DRAIN:                  enq_pct = 10;
        default:                    enq_pct = 50;
      endcase
      for (int i = 0; i < len && items_sent < ITEM_TOTAL; i++) begin
        req = ($urandom_range(0, 99) < enq_pct) ? REQ_ENQUEUE : REQ_DEQUEUE;
        cls = (seg == SEG_FILL_ONE) ? seg_cls : CLASS_W'($urandom_range(0, 3));
        send_item(req, IO_HANDLE_W'($urandom_range(0, 255)), cls);
      end
    end
    in_tvalid <= 1'b0;

    // Let the last replies drain out
    w = 0;
    while (prio_chk.expected_replies.size() != 0 && w < 2000) begin
      @(posedge clk);
      w++;
    end
    repeat (10) @(posedge clk);
    prio_chk.close_out();

    $display("Ran %0d requests: %0d enqueued, %0d dropped full, %0d empty dequeues",
             items_sent, prio_chk.n_enq, prio_chk.n_full, prio_chk.n_empty);
    $display("%0d dequeued (high %0d, system %0d, low %0d), peak occupancy %0d",
             prio_chk.n_deq, prio_chk.deq_per_class[0], prio_chk.deq_per_class[1],
             prio_chk.deq_per_class[2], prio_chk.peak_held);
    if (prio_chk.failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/tcpq_pkg.sv
rtl/tcpq_ctrl.sv
rtl/tcpq_dpath.sv
rtl/three_class_priority_queue.sv
verif/tb_top.sv
